FILE: hdl/dce_pkg.sv
// shared types and constants for the dictionary codeword emitter
// no dependencies; imported by the serial divider, the top level and the testbench
package dce_pkg;

  // widest size and bound register
  localparam int SIZE_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int BYTE_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE_SIZE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE_TWO_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE_TO_THREE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_BYTE_BOUND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE_BOUND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_DIGIT_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOURTH_DIGIT_OFFSET   = 3'd6;

  // input operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // digit positions, lead digit of a four byte codeword first
  localparam logic [1:0] POS_FOURTH = 2'd3;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_FIRST  = 2'd0;

  // request from the sequencer to the serial divider
  typedef struct packed {
    logic start;
    logic reduce;  // only reduce the operand modulo the table depth
  } div_req_t;

endpackage

FILE: hdl/dce_serial_div.sv
// bit-serial restoring divider with a running table-depth modulo of the quotient
// depends on dce_pkg; one quotient bit per cycle
module dce_serial_div #(
  parameter int INDEX_BITS  = 24,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dce_pkg::div_req_t              req,
  input  logic [INDEX_BITS-1:0]          dividend,
  input  logic [dce_pkg::SIZE_W-1:0]     divisor,
  output logic                           done,
  output logic [INDEX_BITS-1:0]          remainder,
  output logic [$clog2(TABLE_DEPTH)-1:0] digit_mod
);
  import dce_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PW   = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;
  localparam int CNTW = $clog2(INDEX_BITS + 1);
  localparam logic [AW:0]   DEPTH_A  = (AW+1)'(TABLE_DEPTH);
  // quotient of a division by zero is all ones over 64 bits
  localparam logic [AW-1:0] ALL1_MOD = AW'(64'hFFFF_FFFF_FFFF_FFFF % TABLE_DEPTH);

  logic                  run_r;
  logic                  done_r;
  logic [CNTW-1:0]       cnt_r;
  logic [INDEX_BITS-1:0] dvd_r;
  logic [PW-1:0]         part_r;
  logic [AW-1:0]         acc_r;
  logic                  reduce_r;
  logic                  zero_r;

  logic [PW:0]   trial;
  logic [PW+1:0] diff;
  logic          qbit;
  logic [PW-1:0] part_nxt;
  logic          in_bit;
  logic [AW:0]   accx;
  logic [AW:0]   accd;
  logic [AW-1:0] acc_nxt;

  always_comb begin
    trial    = {part_r, dvd_r[INDEX_BITS-1]};
    diff     = {1'b0, trial} - (PW+2)'(divisor);
    qbit     = ~diff[PW+1];
    part_nxt = qbit ? diff[PW-1:0] : trial[PW-1:0];
    // fold each new bit into the residue modulo the table depth
    in_bit   = reduce_r ? dvd_r[INDEX_BITS-1] : qbit;
    accx     = {acc_r, in_bit};
    accd     = accx - DEPTH_A;
    acc_nxt  = (accx >= DEPTH_A) ? accd[AW-1:0] : accx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(INDEX_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r    <= dividend;
      part_r   <= '0;
      acc_r    <= '0;
      reduce_r <= req.reduce;
      zero_r   <= (divisor == '0);
    end else if (run_r) begin
      dvd_r  <= {dvd_r[INDEX_BITS-2:0], 1'b0};
      part_r <= part_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = part_r[INDEX_BITS-1:0];
  assign digit_mod = (zero_r && !reduce_r) ? ALL1_MOD : acc_r;

endmodule

FILE: hdl/dictionary_codeword_emitter_unit.sv
// top level of the dictionary codeword emitter: config registers, sequencer, symbol memory
// depends on dce_pkg and dce_serial_div
//
// A load word (in_operation 0) writes one symbol table entry in the cycle it is taken and
// leaves busy low. An encode word raises busy and returns one to four bytes, lead byte
// first, each shown for a single cycle on out_strobe with out_last_byte on the final one;
// the receiver must take every strobed byte, there is no back-pressure. An encode word
// keeps busy high through S_SEL and S_SUB, which pick the level and subtract its bound,
// and then through each digit: S_START launches the divider, S_DIV waits while it
// resolves the quotient bits over the full index width and hands the digit over, S_ADDR
// forms the table address and reads the memory, and S_EMIT shows the byte. Table
// contents are undefined after reset until loaded. Configuration writes are always
// accepted and must only be issued while busy is low.
module dictionary_codeword_emitter_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [dce_pkg::BYTE_W-1:0]       in_table_address,
  input  logic [dce_pkg::BYTE_W-1:0]       in_table_value,
  input  logic [INDEX_BITS-1:0]            in_word_index,
  output logic                             out_strobe,
  output logic [dce_pkg::BYTE_W-1:0]       out_code_byte,
  output logic                             out_last_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dce_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CMPW = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;
  localparam logic [AW:0]  DEPTH_A  = (AW+1)'(TABLE_DEPTH);
  localparam logic [11:0]  DEPTH_12 = 12'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SEL   = 7'b0000010,
    S_SUB   = 7'b0000100,
    S_START = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_ADDR  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  // reduce a byte modulo the table depth; the depth must be at least 16, which is not enforced
  function automatic logic [AW-1:0] mod_depth(input logic [BYTE_W-1:0] x);
    logic [11:0] acc;
    acc = {4'b0, x};
    for (int k = 3; k >= 0; k--) begin
      if (acc >= (DEPTH_12 << k)) acc = acc - (DEPTH_12 << k);
    end
    return acc[AW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [7:0]  lvl1_r;
  logic [15:0] lvl12_r;
  logic [23:0] lvl123_r;
  logic [23:0] bound3_r;
  logic [23:0] bound4_r;
  logic [7:0]  off3_r;
  logic [7:0]  off4_r;

  logic [INDEX_BITS-1:0] v_r;
  logic [INDEX_BITS-1:0] r_r;
  logic [23:0]           bound_r;
  logic [1:0]            pos_r;
  logic [AW-1:0]         digit_r;
  logic [BYTE_W-1:0]     rdata_r;

  logic [BYTE_W-1:0]     sym_mem [TABLE_DEPTH];

  logic                  accept;
  logic [CMPW-1:0]       vext;
  logic [CMPW-1:0]       rdiff;
  logic [SIZE_W-1:0]     div_divisor;
  logic [BYTE_W-1:0]     offset;
  logic [AW:0]           addr_sum;
  logic [AW:0]           addr_wrap;
  logic [AW-1:0]         rd_addr;
  div_req_t              div_req;
  logic                  div_done;
  logic [INDEX_BITS-1:0] div_rem;
  logic [AW-1:0]         div_mod;

  assign accept    = start && !busy;
  assign busy      = !state_r[0];
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl1_r   <= 8'd1;
      lvl12_r  <= 16'd1;
      lvl123_r <= 24'd1;
      bound3_r <= '0;
      bound4_r <= '0;
      off3_r   <= '0;
      off4_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEVEL_ONE_SIZE:      lvl1_r   <= cfg_data[7:0];
        REG_LEVEL_ONE_TWO_SIZE:  lvl12_r  <= cfg_data[15:0];
        REG_LEVEL_ONE_TO_THREE:  lvl123_r <= cfg_data;
        REG_THREE_BYTE_BOUND:    bound3_r <= cfg_data;
        REG_FOUR_BYTE_BOUND:     bound4_r <= cfg_data;
        REG_THIRD_DIGIT_OFFSET:  off3_r   <= cfg_data[7:0];
        REG_FOURTH_DIGIT_OFFSET: off4_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_operation == OP_ENCODE) state_nxt = S_SEL;
      S_SEL:   state_nxt = S_SUB;
      S_SUB:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_EMIT;
      S_EMIT:  state_nxt = (pos_r == POS_FIRST) ? S_IDLE : S_START;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign vext  = CMPW'(v_r);
  assign rdiff = vext - CMPW'(bound_r);

  always_comb begin
    unique case (pos_r)
      POS_FOURTH: begin
        div_divisor = lvl123_r;
        offset      = off4_r;
      end
      POS_THIRD: begin
        div_divisor = SIZE_W'(lvl12_r);
        offset      = off3_r;
      end
      POS_SECOND: begin
        div_divisor = SIZE_W'(lvl1_r);
        offset      = lvl1_r;
      end
      default: begin
        div_divisor = '0;
        offset      = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) v_r <= in_word_index - INDEX_BITS'(1);
    if (state_r == S_SEL) begin
      // level choice on the zero-based index
      priority if (vext >= CMPW'(bound4_r)) begin
        pos_r   <= POS_FOURTH;
        bound_r <= bound4_r;
      end else if (vext >= CMPW'(bound3_r)) begin
        pos_r   <= POS_THIRD;
        bound_r <= bound3_r;
      end else if (vext >= CMPW'(lvl1_r)) begin
        pos_r   <= POS_SECOND;
        bound_r <= 24'(lvl1_r);
      end else begin
        pos_r   <= POS_FIRST;
        bound_r <= '0;
      end
    end
    if (state_r == S_SUB) r_r <= rdiff[INDEX_BITS-1:0];
    if (state_r == S_DIV && div_done) begin
      r_r     <= div_rem;
      digit_r <= div_mod;
    end
    if (state_r == S_EMIT && pos_r != POS_FIRST) pos_r <= pos_r - 2'd1;
  end

  assign div_req.start  = (state_r == S_START);
  assign div_req.reduce = (pos_r == POS_FIRST);

  dce_serial_div #(
    .INDEX_BITS  (INDEX_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (r_r),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem),
    .digit_mod (div_mod)
  );

  // table address wraps modulo the depth
  always_comb begin
    addr_sum  = {1'b0, mod_depth(offset)} + {1'b0, digit_r};
    addr_wrap = addr_sum - DEPTH_A;
    rd_addr   = (addr_sum >= DEPTH_A) ? addr_wrap[AW-1:0] : addr_sum[AW-1:0];
  end

  // symbol table
  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_LOAD) sym_mem[mod_depth(in_table_address)] <= in_table_value;
    if (state_r == S_ADDR) rdata_r <= sym_mem[rd_addr];
  end

  assign out_strobe    = (state_r == S_EMIT);
  assign out_code_byte = rdata_r;
  assign out_last_byte = (pos_r == POS_FIRST);

endmodule

FILE: hdl/dce_checker.sv
// port-level checks for the dictionary codeword emitter, attached by bind
// depends on dictionary_codeword_emitter_unit port names
module dce_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_strobe,
  input logic out_last_byte
);

  // bytes only come out while an encode word is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("byte strobed while idle");

  // a load word returns nothing and leaves the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_operation) |=> !busy)
    else $error("load word raised busy");

  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation) |=> busy)
    else $error("encode word not taken up");

  // no two bytes of a codeword are strobed back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back byte strobes");

  // final byte ends the encode
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_byte) |=> !busy)
    else $error("still busy after last byte");

endmodule

bind dictionary_codeword_emitter_unit dce_checker u_dce_checker (.*);

FILE: test/tb_dictionary_codeword_emitter_unit.sv
// testbench for dictionary_codeword_emitter_unit: directed and random words checked
// byte by byte against a predictor of the codeword levels and the symbol table
// depends on dce_pkg and the emitter RTL
module tb_dictionary_codeword_emitter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dce_pkg::*;

  localparam int INDEX_W   = 24;
  localparam int RUN_LIMIT = 600000;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
  } code_byte_t;

  class codeword_scoreboard;
    logic [7:0]  symbols [256];
    bit          written [256];
    logic [7:0]  level_one_size;
    logic [15:0] level_one_two_size;
    logic [23:0] level_one_to_three_size;
    logic [23:0] three_byte_bound;
    logic [23:0] four_byte_bound;
    logic [7:0]  third_digit_offset;
    logic [7:0]  fourth_digit_offset;
    logic [7:0]  read_addr [4];
    code_byte_t  expected_bytes [$];
    int          mismatches;

    function new();
      foreach (written[i]) begin
        written[i] = 1'b0;
        symbols[i] = 8'h00;
      end
      level_one_size          = 8'd1;
      level_one_two_size      = 16'd1;
      level_one_to_three_size = 24'd1;
      three_byte_bound        = 24'd0;
      four_byte_bound         = 24'd0;
      third_digit_offset      = 8'd0;
      fourth_digit_offset     = 8'd0;
      mismatches              = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
      case (idx)
        REG_LEVEL_ONE_SIZE:      level_one_size = data[7:0];
        REG_LEVEL_ONE_TWO_SIZE:  level_one_two_size = data[15:0];
        REG_LEVEL_ONE_TO_THREE:  level_one_to_three_size = data;
        REG_THREE_BYTE_BOUND:    three_byte_bound = data;
        REG_FOUR_BYTE_BOUND:     four_byte_bound = data;
        REG_THIRD_DIGIT_OFFSET:  third_digit_offset = data[7:0];
        REG_FOURTH_DIGIT_OFFSET: fourth_digit_offset = data[7:0];
        default: ;
      endcase
    endfunction

    // a zero size gives an all-ones quotient
    function logic [7:0] digit_of(logic [23:0] r, logic [23:0] d);
      logic [23:0] q;
      q = (d == 24'd0) ? 24'hFFFFFF : r / d;
      return q[7:0];
    endfunction

    function logic [23:0] rest_of(logic [23:0] r, logic [23:0] d);
      return (d == 24'd0) ? r : r % d;
    endfunction

    // fills read_addr with the table entries of the codeword, lead byte first
    function int table_reads(logic [INDEX_W-1:0] word_index);
      logic [23:0] v, r, l1, l12;
      int n, k;
      l1  = {16'd0, level_one_size};
      l12 = {8'd0, level_one_two_size};
      v   = word_index - 24'd1;
      n   = (v >= four_byte_bound) ? 4 : (v >= three_byte_bound) ? 3 : (v >= l1) ? 2 : 1;
      r   = v - ((n == 4) ? four_byte_bound : (n == 3) ? three_byte_bound :
                 (n == 2) ? l1 : 24'd0);
      k   = 0;
      if (n == 4) begin
        read_addr[k] = fourth_digit_offset + digit_of(r, level_one_to_three_size);
        r = rest_of(r, level_one_to_three_size);
        k++;
      end
      if (n >= 3) begin
        read_addr[k] = third_digit_offset + digit_of(r, l12);
        r = rest_of(r, l12);
        k++;
      end
      if (n >= 2) begin
        read_addr[k] = level_one_size + digit_of(r, l1);
        r = rest_of(r, l1);
        k++;
      end
      read_addr[k] = r[7:0];
      return n;
    endfunction

    function void note_word(logic op, logic [7:0] addr, logic [7:0] value,
                            logic [INDEX_W-1:0] word_index);
      int n;
      code_byte_t e;
      if (op == OP_LOAD) begin
        symbols[addr] = value;
        written[addr] = 1'b1;
      end else begin
        n = table_reads(word_index);
        for (int k = 0; k < n; k++) begin
          e.code = symbols[read_addr[k]];
          e.last = (k == n - 1);
          expected_bytes = {expected_bytes, e};
        end
      end
    endfunction

    function void check_byte(logic [7:0] code, logic last);
      code_byte_t e;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: code byte with nothing pending: expected none, actual %h last %b",
                 $time, code, last);
      end else begin
        e = expected_bytes.pop_front();
        if (e.code !== code) begin
          mismatches++;
          $display("%0t: code_byte mismatch: expected %h, actual %h", $time, e.code, code);
        end
        if (e.last !== last) begin
          mismatches++;
          $display("%0t: last_byte mismatch: expected %b, actual %b", $time, e.last, last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_operation;
  logic [BYTE_W-1:0]     in_table_address;
  logic [BYTE_W-1:0]     in_table_value;
  logic [INDEX_W-1:0]    in_word_index;
  logic                  out_strobe;
  logic [BYTE_W-1:0]     out_code_byte;
  logic                  out_last_byte;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  codeword_scoreboard sb;
  bit                 no_idle;
  int                 cycles;

  dictionary_codeword_emitter_unit #(
    .TABLE_DEPTH(256),
    .INDEX_BITS (INDEX_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_table_address(in_table_address),
    .in_table_value  (in_table_value),
    .in_word_index   (in_word_index),
    .out_strobe      (out_strobe),
    .out_code_byte   (out_code_byte),
    .out_last_byte   (out_last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) sb.check_byte(out_code_byte, out_last_byte);
  end

  // one word on the input side, then a random pause before the next
  task automatic send_word(logic op, logic [7:0] addr, logic [7:0] value,
                           logic [INDEX_W-1:0] word_index);
    int gap;
    start            <= 1'b1;
    in_operation     <= op;
    in_table_address <= addr;
    in_table_value   <= value;
    in_word_index    <= word_index;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_word(op, addr, value, word_index);
    if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // entries the codeword reads get loaded first if they never were
  task automatic encode_word(logic [INDEX_W-1:0] word_index);
    int n;
    logic [7:0] addrs [4];
    n = sb.table_reads(word_index);
    for (int k = 0; k < n; k++) addrs[k] = sb.read_addr[k];
    for (int k = 0; k < n; k++) begin
      if (!sb.written[addrs[k]])
        send_word(OP_LOAD, addrs[k], 8'($urandom_range(0, 255)), INDEX_W'($urandom));
    end
    send_word(OP_ENCODE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), word_index);
  endtask

  // index drawn from one bound range, often right at its ends
  task automatic encode_in_level(int level);
    int lo, hi, v;
    case (level)
      0: begin
        lo = 0;
        hi = int'(sb.level_one_size) - 1;
      end
      1: begin
        lo = int'(sb.level_one_size);
        hi = int'(sb.three_byte_bound) - 1;
      end
      2: begin
        lo = int'(sb.three_byte_bound);
        hi = int'(sb.four_byte_bound) - 1;
      end
      default: begin
        lo = int'(sb.four_byte_bound);
        hi = 24'hFFFFFF;
      end
    endcase
    if (hi < lo) v = $urandom_range(0, 24'hFFFFFF);
    else begin
      case ($urandom_range(0, 7))
        0:       v = lo;
        1:       v = hi;
        default: v = $urandom_range(hi, lo);
      endcase
    end
    encode_word(INDEX_W'(v + 1));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_bytes.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic configure(logic [23:0] l1, logic [23:0] l12, logic [23:0] l123,
                           logic [23:0] b3, logic [23:0] b4, logic [23:0] o3,
                           logic [23:0] o4);
    wait_drained();
    cfg_write(REG_LEVEL_ONE_SIZE, l1);
    cfg_write(REG_LEVEL_ONE_TWO_SIZE, l12);
    cfg_write(REG_LEVEL_ONE_TO_THREE, l123);
    cfg_write(REG_THREE_BYTE_BOUND, b3);
    cfg_write(REG_FOUR_BYTE_BOUND, b4);
    cfg_write(REG_THIRD_DIGIT_OFFSET, o3);
    cfg_write(REG_FOURTH_DIGIT_OFFSET, o4);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config(bit well_formed);
    logic [23:0] l1, l12, l123, b3, b4;
    if (well_formed) begin
      // nested radices with bounds laid end to end
      l1   = 24'($urandom_range(1, 255));
      l12  = 24'(l1 * $urandom_range(1, 255));
      l123 = 24'(l12 * $urandom_range(1, 255));
      b3   = l1 + l12;
      b4   = b3 + l123;
    end else begin
      l1   = 24'($urandom_range(0, 255));
      l12  = 24'($urandom_range(0, 16'hFFFF));
      l123 = 24'($urandom_range(0, 24'hFFFFFF));
      b3   = 24'($urandom_range(0, 24'hFFFFFF));
      b4   = 24'($urandom_range(0, 24'hFFFFFF));
    end
    configure(l1, l12, l123, b3, b4, 24'($urandom_range(0, 255)),
              24'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [23:0] boundary [8];
    int pick;
    sb               = new();
    no_idle          = 1'b0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_operation     <= OP_LOAD;
    in_table_address <= '0;
    in_table_value   <= '0;
    in_word_index    <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_LEVEL_ONE_SIZE;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: every index lands in the four byte level
    send_word(OP_LOAD, 8'h00, 8'hFF, 24'hFFFFFF);
    send_word(OP_LOAD, 8'hFF, 8'h00, 24'h000000);
    encode_word(24'd1);
    encode_word(24'd0);
    encode_word(24'hFFFFFF);

    // each side of every level bound
    configure(100, 5000, 100000, 5100, 105100, 150, 170);
    boundary = '{24'd0, 24'd99, 24'd100, 24'd5099, 24'd5100, 24'd105099, 24'd105100,
                 24'hFFFFFE};
    foreach (boundary[i]) encode_word(boundary[i] + 24'd1);

    // zero sizes: all-ones quotient, remainder keeps the dividend
    configure(0, 0, 0, 300, 4000, 10, 20);
    encode_word(24'd6);
    encode_word(24'd1001);
    encode_word(24'd0);

    // widest sizes, offsets that make table addresses wrap
    configure(24'hFF, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF, 24'hFF);
    encode_word(24'hFFFFFF);
    encode_word(24'd0);
    encode_word(24'd200);

    // smallest sizes
    configure(1, 1, 1, 2, 3, 0, 0);
    for (int i = 1; i <= 4; i++) encode_word(24'(i));

    for (int phase = 0; phase < 5; phase++) begin
      random_config(phase != 2);
      repeat (15) begin
        pick = $urandom_range(0, 99);
        if (pick < 25)
          send_word(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    INDEX_W'($urandom));
        else if (pick < 40) encode_word(INDEX_W'($urandom));
        else encode_in_level($urandom_range(0, 3));
      end
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dce_pkg.sv
hdl/dce_serial_div.sv
hdl/dictionary_codeword_emitter_unit.sv
hdl/dce_checker.sv
test/tb_dictionary_codeword_emitter_unit.sv
